FILE: hdl/bfdh_pkg.sv
package bfdh_pkg;

    localparam int BLOOM_BITS = 1024;   // power of two, 64 to 1024
    localparam int NUM_HASHES = 4;      // 1 to 16

    localparam int POS_W      = $clog2(BLOOM_BITS);
    localparam int STORE_AW   = 7;
    localparam int K_W        = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

    localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
    // prime = 2^40 + 0x1b3
    localparam int          PRIME_SHIFT  = 40;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_QUERY  = 3'd2;
    localparam logic [2:0] CMD_LOAD   = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_HASH      = 6'b000010,
        ST_PROBE_RD  = 6'b000100,
        ST_PROBE_CHK = 6'b001000,
        ST_BYTE_RD   = 6'b010000,
        ST_FINISH    = 6'b100000
    } state_t;

    typedef struct packed {
        logic                clear;
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
    } store_req_t;

endpackage

FILE: hdl/bfdh_fnv_round.sv
module bfdh_fnv_round (
    input  logic [63:0] acc,
    input  logic [7:0]  data_byte,
    output logic [63:0] acc_out
);
    import bfdh_pkg::*;

    logic [63:0] mixed;
    logic [72:0] lo_prod;

    assign mixed   = acc ^ {56'd0, data_byte};
    assign lo_prod = mixed * FNV_PRIME_LO;
    assign acc_out = (mixed << PRIME_SHIFT) + lo_prod[63:0];

endmodule

FILE: hdl/bfdh_store.sv
module bfdh_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfdh_pkg::store_req_t req,
    output logic [7:0]           rd_data
);
    import bfdh_pkg::*;

    localparam int DEPTH = 1 << STORE_AW;

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       data_reg;
    logic             data_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                data_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = data_valid_reg ? data_reg : 8'd0;

endmodule

FILE: hdl/bloom_filter_fnv_double_hash.sv
// Bloom filter over a 1024-bit store held as 128 bytes, with clear, insert of a
// precomputed hash pair, query of a 64-bit node id, and byte load and read. One
// transaction is taken at a time; in_stall is high while it runs. A query hashes
// the id and the salted id with FNV-1a 64 through one shared round unit, one
// byte per cycle, then probes the store; each probe is a read on the store's
// single registered read port and then a check, and a query that misses ends
// early. The result then waits in an output register; the next transaction
// may enter while it is held. The store is clear after reset with no sweep.
module bloom_filter_fnv_double_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        salt_we,
    input  logic [63:0] salt_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [63:0] node_id,
    input  logic [63:0] first_hash,
    input  logic [63:0] second_hash,
    input  logic [6:0]  byte_index,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        member_hit,
    output logic [7:0]  read_byte
);
    import bfdh_pkg::*;

    localparam logic [K_W-1:0] K_LAST = K_W'(NUM_HASHES - 1);

    state_t             state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [63:0]        salt_reg;
    logic [63:0]        node_reg, node_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        work_reg, work_next;
    logic [3:0]         round_reg, round_next;
    logic [POS_W-1:0]   sum_reg, sum_next;
    logic [POS_W-1:0]   stride_reg, stride_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               hit_reg, hit_next;
    logic [7:0]         rb_reg, rb_next;
    logic               out_valid_reg, out_valid_next;
    logic               member_hit_reg, member_hit_next;
    logic [7:0]         read_byte_reg, read_byte_next;

    logic [63:0]        fnv_out;
    logic [7:0]         rd_data;
    logic               bit_set;
    store_req_t         store_req;

    bfdh_fnv_round u_round (
        .acc       (acc_reg),
        .data_byte (work_reg[63:56]),
        .acc_out   (fnv_out)
    );

    bfdh_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign bit_set = rd_data[sum_reg[2:0]];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        node_next       = node_reg;
        acc_next        = acc_reg;
        work_next       = work_reg;
        round_next      = round_reg;
        sum_next        = sum_reg;
        stride_next     = stride_reg;
        k_next          = k_reg;
        hit_next        = hit_reg;
        rb_next         = rb_reg;
        out_valid_next  = out_valid_reg;
        member_hit_next = member_hit_reg;
        read_byte_next  = read_byte_reg;
        store_req       = '0;
        in_stall        = (state_reg != ST_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    hit_next = 1'b0;
                    rb_next  = 8'd0;
                    k_next   = '0;
                    case (command)
                        CMD_CLEAR:
                        begin
                            store_req.clear = 1'b1;
                            state_next      = ST_FINISH;
                        end
                        CMD_INSERT:
                        begin
                            sum_next    = first_hash[POS_W-1:0];
                            stride_next = second_hash[POS_W-1:0];
                            state_next  = ST_PROBE_RD;
                        end
                        CMD_QUERY:
                        begin
                            node_next  = node_id;
                            acc_next   = FNV_BASIS;
                            work_next  = node_id;
                            round_next = 4'd0;
                            state_next = ST_HASH;
                        end
                        CMD_LOAD:
                        begin
                            store_req.wr_en   = 1'b1;
                            store_req.wr_addr = byte_index;
                            store_req.wr_data = byte_value;
                            state_next        = ST_FINISH;
                        end
                        CMD_READ:
                        begin
                            store_req.rd_en   = 1'b1;
                            store_req.rd_addr = byte_index;
                            state_next        = ST_BYTE_RD;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_HASH:
            begin
                acc_next   = fnv_out;
                work_next  = work_reg << 8;
                round_next = round_reg + 4'd1;
                if (round_reg[2:0] == 3'd7)
                begin
                    if (!round_reg[3])
                    begin
                        sum_next  = fnv_out[POS_W-1:0];
                        acc_next  = FNV_BASIS;
                        work_next = node_reg ^ salt_reg;
                    end
                    else
                    begin
                        stride_next = fnv_out[POS_W-1:0];
                        hit_next    = 1'b1;
                        state_next  = ST_PROBE_RD;
                    end
                end
            end
            ST_PROBE_RD:
            begin
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = STORE_AW'(sum_reg[POS_W-1:3]);
                state_next        = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    store_req.wr_en   = 1'b1;
                    store_req.wr_addr = STORE_AW'(sum_reg[POS_W-1:3]);
                    store_req.wr_data = rd_data | (8'd1 << sum_reg[2:0]);
                end
                else if (!bit_set)
                begin
                    hit_next = 1'b0;
                end
                sum_next = sum_reg + stride_reg;
                k_next   = k_reg + 1'b1;
                if (k_reg == K_LAST || (cmd_reg == CMD_QUERY && !bit_set))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_BYTE_RD:
            begin
                rb_next    = rd_data;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    member_hit_next = hit_reg;
                    read_byte_next  = rb_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            salt_reg      <= 64'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (salt_we)
            begin
                salt_reg <= salt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        node_reg       <= node_next;
        acc_reg        <= acc_next;
        work_reg       <= work_next;
        round_reg      <= round_next;
        sum_reg        <= sum_next;
        stride_reg     <= stride_next;
        k_reg          <= k_next;
        hit_reg        <= hit_next;
        rb_reg         <= rb_next;
        member_hit_reg <= member_hit_next;
        read_byte_reg  <= read_byte_next;
    end

    assign out_valid  = out_valid_reg;
    assign member_hit = member_hit_reg;
    assign read_byte  = read_byte_reg;

    // a result carries a hit or a byte, never both
    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!member_hit || read_byte == 8'd0))
        else $error("hit and read byte both set");

    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && command == CMD_READ)
        |=> state_reg == ST_BYTE_RD)
        else $error("read byte did not issue store read");

    a_probe_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE_CHK |-> $past(state_reg) == ST_PROBE_RD)
        else $error("probe check without store read");

    a_hash_query_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HASH |-> cmd_reg == CMD_QUERY)
        else $error("hash round outside a query");

endmodule
